/* rtl/core/fpr_pkg.sv */
package fpr_pkg;

  localparam int unsigned PageW  = 20;
  localparam int unsigned TotalW = 16;
  localparam int unsigned CfgW   = 5;

  localparam logic [CfgW-1:0] CfgReset = 5'd4;

  typedef struct packed {
    logic [PageW-1:0] page_number;
    logic             last_ref;
  } fpr_in_t;

  typedef struct packed {
    logic              fault;
    logic              evicted_valid;
    logic [PageW-1:0]  evicted_page;
    logic [TotalW-1:0] fault_total;
    logic              string_done;
  } fpr_out_t;

  // status rippled along the row of frame cells
  typedef struct packed {
    logic hit;
    logic ev_valid;
  } fpr_link_t;

endpackage

/* rtl/core/fpr_cell.sv */
module fpr_cell #(
  parameter int unsigned PAGE_BITS = 20,
  parameter int unsigned SW        = 4,
  parameter int unsigned IDX       = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clr_i,
  input  logic                 wr_i,
  input  logic [SW-1:0]        wr_slot_i,
  input  logic [SW-1:0]        sel_slot_i,
  input  logic [PAGE_BITS-1:0] page_i,
  input  fpr_pkg::fpr_link_t   link_i,
  input  logic [PAGE_BITS-1:0] ev_page_i,
  output fpr_pkg::fpr_link_t   link_o,
  output logic [PAGE_BITS-1:0] ev_page_o
);
  import fpr_pkg::*;

  localparam logic [SW-1:0] MyIdx = SW'(IDX);

  logic                 valid_q, valid_d;
  logic [PAGE_BITS-1:0] page_q;
  logic                 we, sel;

  assign we  = wr_i && (wr_slot_i == MyIdx);
  assign sel = (sel_slot_i == MyIdx) && valid_q;

  assign link_o.hit      = link_i.hit || (valid_q && (page_q == page_i));
  assign link_o.ev_valid = link_i.ev_valid || sel;
  assign ev_page_o       = ev_page_i | (sel ? page_q : '0);

  always_comb begin
    valid_d = valid_q;
    if (clr_i) begin
      valid_d = 1'b0;
    end else if (we) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      page_q <= page_i;
    end
  end

endmodule

/* rtl/core/fifo_page_replacement_top.sv */
// FIFO page replacement engine. Each item is one page reference; one result item
// comes back per reference in the cycle after it is taken, and a new reference is
// taken every cycle while the result side keeps up. The resident set lives in a
// row of FRAMES frame cells that all compare the reference in the same cycle; the
// hit flag and the page to be evicted ripple along the row, so that ripple sets
// the clock period. The user must write frames_in_use (cfg_we_i/cfg_data_i) only
// while idle, which the block does not enforce. 0 acts as 1; above FRAMES, as FRAMES.
// An item with last_ref set returns the final fault total and clears frames and count.
module fifo_page_replacement_top #(
  parameter int unsigned FRAMES    = 16,
  parameter int unsigned PAGE_BITS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  fpr_pkg::fpr_in_t             in_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output fpr_pkg::fpr_out_t            out_o,
  input  logic                         cfg_we_i,
  input  logic [fpr_pkg::CfgW-1:0]     cfg_data_i
);
  import fpr_pkg::*;

  localparam int unsigned SW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNTW = $clog2(FRAMES + 1);
  localparam int unsigned WW   = ((CNTW > CfgW) ? CNTW : CfgW) + 1;

  logic [CfgW-1:0]   cfg_q;
  logic [SW-1:0]     oldest_q, oldest_d;
  logic [CNTW-1:0]   filled_q, filled_d;
  logic [TotalW-1:0] count_q, count_d, count_inc;
  logic              out_valid_q;
  fpr_out_t          out_q, out_d;

  logic                 accept, miss, free, do_wr, clr;
  logic [WW-1:0]        cfg_w, frames_w, cap, slot_nxt;
  logic [SW-1:0]        wr_slot;
  logic [PAGE_BITS+PageW-1:0] page_tmp, ev_tmp;
  logic [PAGE_BITS-1:0] page;

  fpr_link_t            link [FRAMES+1];
  logic [PAGE_BITS-1:0] ev_page [FRAMES+1];

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign page_tmp = {{PAGE_BITS{1'b0}}, in_i.page_number};
  assign page     = page_tmp[PAGE_BITS-1:0];

  assign cfg_w    = WW'(cfg_q);
  assign frames_w = WW'(FRAMES);
  always_comb begin
    if (cfg_w == '0) begin
      cap = WW'(1);
    end else if (cfg_w > frames_w) begin
      cap = frames_w;
    end else begin
      cap = cfg_w;
    end
  end

  assign miss    = !link[FRAMES].hit;
  assign free    = WW'(filled_q) < cap;
  assign do_wr   = accept && miss;
  assign clr     = accept && in_i.last_ref;
  assign wr_slot = free ? filled_q[SW-1:0] : oldest_q;

  assign link[0]    = '0;
  assign ev_page[0] = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    fpr_cell #(
      .PAGE_BITS (PAGE_BITS),
      .SW        (SW),
      .IDX       (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clr_i      (clr),
      .wr_i       (do_wr),
      .wr_slot_i  (wr_slot),
      .sel_slot_i (oldest_q),
      .page_i     (page),
      .link_i     (link[g]),
      .ev_page_i  (ev_page[g]),
      .link_o     (link[g+1]),
      .ev_page_o  (ev_page[g+1])
    );
  end

  assign ev_tmp    = {{PageW{1'b0}}, ev_page[FRAMES]};
  assign slot_nxt  = WW'(oldest_q) + WW'(1);
  assign count_inc = (count_q == '1) ? count_q : count_q + TotalW'(1);

  always_comb begin
    oldest_d = oldest_q;
    filled_d = filled_q;
    count_d  = count_q;
    out_d    = out_q;
    if (accept) begin
      if (miss) begin
        count_d = count_inc;
        if (free) begin
          filled_d = filled_q + CNTW'(1);
        end else begin
          oldest_d = (slot_nxt >= cap) ? '0 : slot_nxt[SW-1:0];
        end
      end
      out_d.fault         = miss;
      out_d.evicted_valid = miss && !free && link[FRAMES].ev_valid;
      out_d.evicted_page  = (miss && !free && link[FRAMES].ev_valid) ?
                            ev_tmp[PageW-1:0] : '0;
      out_d.fault_total   = count_d;
      out_d.string_done   = in_i.last_ref;
      if (in_i.last_ref) begin
        oldest_d = '0;
        filled_d = '0;
        count_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CfgReset;
      oldest_q    <= '0;
      filled_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_data_i;
      end
      oldest_q <= oldest_d;
      filled_q <= filled_d;
      count_q  <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

endmodule

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fpr_pkg::*;

  localparam int unsigned NumFrames = 16;

  typedef enum logic [0:0] {EntRef, EntCfg} entry_kind_e;

  typedef struct {
    entry_kind_e     kind;
    fpr_in_t         item;
    logic [CfgW-1:0] setting;
    int unsigned     idle;
  } pending_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  fpr_in_t         in_item = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  fpr_out_t        out_item;
  logic            cfg_we = 1'b0;
  logic [CfgW-1:0] cfg_data = '0;

  pending_t    pending_q[$];
  fpr_out_t    expected_q[$];
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  int unsigned idle_pct = 15;
  bit          calm = 1'b0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned cycle_limit = 5000000;

  // resident set as the block should hold it
  logic [PageW-1:0]  frame_page [NumFrames];
  bit                frame_used [NumFrames];
  int unsigned       ring_head = 0;
  int unsigned       fill_count = 0;
  logic [TotalW-1:0] fault_count = '0;
  logic [CfgW-1:0]   frames_cfg = CfgReset;

  fifo_page_replacement_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void clear_frames();
    foreach (frame_used[i]) frame_used[i] = 1'b0;
    ring_head   = 0;
    fill_count  = 0;
    fault_count = '0;
  endfunction

  function automatic fpr_out_t predict_reference(fpr_in_t req);
    fpr_out_t    res;
    int unsigned cap;
    int unsigned slot;
    bit          hit;
    cap = (frames_cfg == 0) ? 1 :
          ((32'(frames_cfg) > NumFrames) ? NumFrames : 32'(frames_cfg));
    hit = 1'b0;
    res = '0;
    for (int i = 0; i < NumFrames; i++) begin
      if (frame_used[i] && frame_page[i] == req.page_number) hit = 1'b1;
    end
    if (!hit) begin
      res.fault = 1'b1;
      if (fill_count < cap) begin
        slot = fill_count;
        fill_count++;
      end else begin
        slot = ring_head;
        if (frame_used[slot]) begin
          res.evicted_valid = 1'b1;
          res.evicted_page  = frame_page[slot];
        end
        ring_head = (slot + 1 >= cap) ? 0 : slot + 1;
      end
      frame_page[slot] = req.page_number;
      frame_used[slot] = 1'b1;
      if (fault_count != '1) fault_count++;
    end
    res.fault_total = fault_count;
    res.string_done = req.last_ref;
    if (req.last_ref) clear_frames();
    return res;
  endfunction

  task automatic add_ref(logic [PageW-1:0] page, bit last);
    pending_t e;
    e.kind             = EntRef;
    e.item.page_number = page;
    e.item.last_ref    = last;
    e.setting          = '0;
    e.idle             = 0;
    pending_q.push_back(e);
  endtask

  task automatic add_cfg(logic [CfgW-1:0] value, int unsigned pct);
    pending_t e;
    e.kind    = EntCfg;
    e.item    = '0;
    e.setting = value;
    e.idle    = pct;
    pending_q.push_back(e);
  endtask

  // span 0 gives fully random pages, otherwise pages come from a pool of span
  task automatic add_string(int unsigned len, int unsigned span, bit close);
    logic [PageW-1:0] pool [40];
    logic [PageW-1:0] page;
    bit               narrow;
    narrow = $urandom_range(0, 2) == 0;
    foreach (pool[i]) pool[i] = narrow ? PageW'($urandom_range(0, 63)) : PageW'($urandom);
    for (int unsigned n = 0; n < len; n++) begin
      page = (span == 0) ? PageW'($urandom) : pool[$urandom_range(0, span - 1)];
      add_ref(page, close && n == len - 1);
    end
  endtask

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
  endtask

  // driver: prediction happens at acceptance
  always @(posedge clk) begin
    logic            valid_nxt;
    fpr_in_t         item_nxt;
    logic            we_nxt;
    logic [CfgW-1:0] data_nxt;
    valid_nxt = in_valid;
    item_nxt  = in_item;
    we_nxt    = 1'b0;
    data_nxt  = cfg_data;
    if (rst_n) begin
      if (cfg_we) frames_cfg = cfg_data;
      if (in_valid && in_ready) begin
        expected_q.push_back(predict_reference(in_item));
        valid_nxt = 1'b0;
      end
      calm = pending_q.size() < 150;
      if (!valid_nxt) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0) begin
          if (pending_q[0].kind == EntRef) begin
            item_nxt  = pending_q[0].item;
            valid_nxt = 1'b1;
            void'(pending_q.pop_front());
            if (!calm && $urandom_range(0, 99) < idle_pct) send_gap = $urandom_range(1, 11);
          end else if (expected_q.size() == 0) begin
            we_nxt   = 1'b1;
            data_nxt = pending_q[0].setting;
            idle_pct = pending_q[0].idle;
            void'(pending_q.pop_front());
          end
        end
      end
    end
    in_valid <= valid_nxt;
    in_item  <= item_nxt;
    cfg_we   <= we_nxt;
    cfg_data <= data_nxt;
  end

  // monitor
  always @(posedge clk) begin
    fpr_out_t want;
    logic     ready_nxt;
    ready_nxt = 1'b1;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 50)
            $display("%0t: result with nothing expected, got %p", $time, out_item);
        end else begin
          want = expected_q.pop_front();
          if (out_item.fault !== want.fault)
            note_mismatch("fault", 32'(want.fault), 32'(out_item.fault));
          if (out_item.evicted_valid !== want.evicted_valid)
            note_mismatch("evicted_valid", 32'(want.evicted_valid),
                          32'(out_item.evicted_valid));
          if (out_item.evicted_page !== want.evicted_page)
            note_mismatch("evicted_page", 32'(want.evicted_page),
                          32'(out_item.evicted_page));
          if (out_item.fault_total !== want.fault_total)
            note_mismatch("fault_total", 32'(want.fault_total),
                          32'(out_item.fault_total));
          if (out_item.string_done !== want.string_done)
            note_mismatch("string_done", 32'(want.string_done),
                          32'(out_item.string_done));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        ready_nxt = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
        recv_stall = $urandom_range(0, 10);
        ready_nxt  = 1'b0;
      end
    end
    out_ready <= ready_nxt;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > cycle_limit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int unsigned     total;
    int unsigned     len;
    int unsigned     span;
    int unsigned     cap;
    logic [CfgW-1:0] setting;

    // reset frame count of 4: fill, then evict the two oldest
    add_ref(20'h00000, 1'b0);
    add_ref(20'hFFFFF, 1'b0);
    add_ref(20'h00001, 1'b0);
    add_ref(20'h00002, 1'b0);
    add_ref(20'h00003, 1'b0);
    add_ref(20'h00000, 1'b1);
    // zero frames acts as one
    add_cfg(5'd0, 15);
    add_ref(20'h00007, 1'b0);
    add_ref(20'h00007, 1'b0);
    add_ref(20'h00008, 1'b1);
    // oversized count acts as the full row
    add_cfg(5'd31, 15);
    for (int unsigned n = 0; n < 17; n++) add_ref(PageW'(20'h5A5A0 + n), n == 16);

    // single frame: every reference misses, and all but the first evict
    add_cfg(5'd1, 0);
    for (int unsigned n = 0; n < 60; n++)
      add_ref(n[0] ? 20'hABCDE : 20'h12345, n == 59);

    total = 0;
    while (total < 1060) begin
      case ($urandom_range(0, 7))
        0:       setting = 5'd0;
        1:       setting = 5'd1;
        2:       setting = 5'd16;
        3:       setting = 5'd17;
        4:       setting = 5'd31;
        default: setting = CfgW'($urandom_range(2, 15));
      endcase
      cap = (setting == 0) ? 1 :
            ((32'(setting) > NumFrames) ? NumFrames : 32'(setting));
      add_cfg(setting, $urandom_range(0, 3) * 12);
      repeat ($urandom_range(1, 4)) begin
        len  = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
        span = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, cap + 6);
        add_string(len, span, $urandom_range(0, 3) != 0);
        total += len;
      end
    end
    add_string($urandom_range(5, 30), $urandom_range(1, 8), 1'b1);
    cycle_limit = 100 * pending_q.size() + 20000;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
